[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/pru_pkg.sv]
// Types and constants of the pixel replication upscaler.
`default_nettype none
package pru_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_SCALE   = 64;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int COL_W       = ADDR_W + 1;
    localparam int REP_W       = $clog2(MAX_SCALE);
    localparam int SCALE_W     = 7;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 2;

    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);
    localparam int RES_SUM_W   = RES_CNT_W + 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_PIXEL  = 2'd1,
        ST_NONE   = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        op_t    op;
        pixel_t px;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        pixel_t     px;
        logic       row_end;
        logic [1:0] pad;
        logic       image_end;
    } result_t;

endpackage
`default_nettype wire

[src/pru_front.sv]
// Front end: accepts input beats, decodes the opcode, queues commands.
`default_nettype none
module pru_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic         opcode,
    input  wire logic [7:0]   blue_in,
    input  wire logic [7:0]   green_in,
    input  wire logic [7:0]   red_in,
    output logic              full,
    output logic              cmd_valid,
    output pru_pkg::cmd_t     cmd,
    input  wire logic         cmd_take
);
    import pru_pkg::*;

    cmd_t                 entries_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_push;
    cmd_t                 in_cmd;

    always_comb
    begin
        in_cmd.op       = op_t'(opcode);
        in_cmd.px.blue  = blue_in;
        in_cmd.px.green = green_in;
        in_cmd.px.red   = red_in;
    end

    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (cmd_take)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CMD_CNT_W'(do_push) - CMD_CNT_W'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

[src/pru_back.sv]
// Back end: configuration, line buffer, row/pixel repeat counters, result stage.
`default_nettype none
module pru_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [pru_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pru_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            cmd_valid,
    input  pru_pkg::cmd_t                        cmd,
    output logic                                 cmd_take,
    input  wire logic [pru_pkg::RES_CNT_W-1:0]   res_level,
    output logic                                 res_push,
    output pru_pkg::result_t                     res
);
    import pru_pkg::*;

    // effective (clamped) configuration
    logic [SCALE_W-1:0]  scale_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [COL_W-1:0]    wc_reg, wc_next;
    logic                row_ready_reg, row_ready_next;
    logic [ADDR_W-1:0]   rc_reg, rc_next;
    logic [REP_W-1:0]    prep_reg, prep_next;
    logic [REP_W-1:0]    rrep_reg, rrep_next;
    logic [HEIGHT_W-1:0] row_idx_reg, row_idx_next;

    pixel_t              line_store_reg [MAX_WIDTH];
    pixel_t              rd_pixel_reg;

    logic                s2_valid_reg;
    status_t             s2_status_reg, s2_status_next;
    logic                s2_row_end_reg, s2_row_end_next;
    logic [1:0]          s2_pad_reg, s2_pad_next;
    logic                s2_img_end_reg, s2_img_end_next;

    logic                issue;
    logic                mem_we;
    logic                rd_en;
    logic [COL_W-1:0]    wc_inc;
    logic                last_rep, last_col, last_rrep, last_row;
    logic [HEIGHT_W:0]   row_inc;
    logic [3:0]          pad_prod;
    logic [RES_SUM_W-1:0] pending;

    // configuration, clamped on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                CFG_SCALE:
                begin
                    if (cfg_wdata[SCALE_W-1:0] == '0)
                        scale_reg <= SCALE_W'(1);
                    else if (cfg_wdata[SCALE_W-1:0] > SCALE_W'(MAX_SCALE))
                        scale_reg <= SCALE_W'(MAX_SCALE);
                    else
                        scale_reg <= cfg_wdata[SCALE_W-1:0];
                end
                CFG_WIDTH:
                begin
                    if (cfg_wdata[WIDTH_W-1:0] == '0)
                        width_reg <= WIDTH_W'(1);
                    else if (cfg_wdata[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH))
                        width_reg <= WIDTH_W'(MAX_WIDTH);
                    else
                        width_reg <= cfg_wdata[WIDTH_W-1:0];
                end
                CFG_HEIGHT:
                begin
                    if (cfg_wdata[HEIGHT_W-1:0] == '0)
                        height_reg <= HEIGHT_W'(1);
                    else
                        height_reg <= cfg_wdata[HEIGHT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // issue only when the result queue has room for this beat and the one in flight
    assign pending  = {1'b0, res_level} + RES_SUM_W'(s2_valid_reg);
    assign issue    = cmd_valid && (pending < RES_SUM_W'(RES_DEPTH));
    assign cmd_take = issue;

    assign wc_inc    = wc_reg + 1'b1;
    assign last_rep  = ({1'b0, prep_reg} + SCALE_W'(1)) >= scale_reg;
    assign last_col  = ({1'b0, rc_reg} + WIDTH_W'(1)) >= width_reg;
    assign last_rrep = ({1'b0, rrep_reg} + SCALE_W'(1)) >= scale_reg;
    assign row_inc   = {1'b0, row_idx_reg} + 1'b1;
    assign last_row  = row_inc >= {1'b0, height_reg};
    // (w * s) mod 4 only needs the low two bits of each
    assign pad_prod  = {2'b00, width_reg[1:0]} * {2'b00, scale_reg[1:0]};

    always_comb
    begin
        wc_next         = wc_reg;
        row_ready_next  = row_ready_reg;
        rc_next         = rc_reg;
        prep_next       = prep_reg;
        rrep_next       = rrep_reg;
        row_idx_next    = row_idx_reg;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        s2_status_next  = ST_NONE;
        s2_row_end_next = 1'b0;
        s2_pad_next     = 2'b00;
        s2_img_end_next = 1'b0;
        if (issue)
        begin
            case (cmd.op)
                OP_PUSH:
                begin
                    if (row_ready_reg)
                    begin
                        s2_status_next = ST_REJECT;
                    end
                    else if (wc_reg >= width_reg)
                    begin
                        // width shrank under a partial row: close it out
                        row_ready_next = 1'b1;
                        wc_next        = '0;
                        s2_status_next = ST_REJECT;
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        s2_status_next = ST_STORED;
                        if (wc_inc >= width_reg)
                        begin
                            row_ready_next = 1'b1;
                            wc_next        = '0;
                        end
                        else
                        begin
                            wc_next = wc_inc;
                        end
                    end
                end
                OP_PULL:
                begin
                    if (!row_ready_reg)
                    begin
                        s2_status_next = ST_NONE;
                    end
                    else
                    begin
                        rd_en           = 1'b1;
                        s2_status_next  = ST_PIXEL;
                        s2_row_end_next = last_rep && last_col;
                        s2_pad_next     = (last_rep && last_col) ? pad_prod[1:0] : 2'b00;
                        s2_img_end_next = last_rep && last_col && last_rrep && last_row;
                        if (!last_rep)
                        begin
                            prep_next = prep_reg + 1'b1;
                        end
                        else
                        begin
                            prep_next = '0;
                            if (!last_col)
                            begin
                                rc_next = rc_reg + 1'b1;
                            end
                            else
                            begin
                                rc_next = '0;
                                if (!last_rrep)
                                begin
                                    rrep_next = rrep_reg + 1'b1;
                                end
                                else
                                begin
                                    rrep_next      = '0;
                                    row_ready_next = 1'b0;
                                    row_idx_next   = last_row ? '0 : row_inc[HEIGHT_W-1:0];
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg        <= '0;
            row_ready_reg <= 1'b0;
            rc_reg        <= '0;
            prep_reg      <= '0;
            rrep_reg      <= '0;
            row_idx_reg   <= '0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            wc_reg        <= wc_next;
            row_ready_reg <= row_ready_next;
            rc_reg        <= rc_next;
            prep_reg      <= prep_next;
            rrep_reg      <= rrep_next;
            row_idx_reg   <= row_idx_next;
            s2_valid_reg  <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_status_reg  <= s2_status_next;
        s2_row_end_reg <= s2_row_end_next;
        s2_pad_reg     <= s2_pad_next;
        s2_img_end_reg <= s2_img_end_next;
    end

    // line buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_store_reg[wc_reg[ADDR_W-1:0]] <= cmd.px;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_pixel_reg <= line_store_reg[rc_reg];
        end
    end

    always_comb
    begin
        res_push      = s2_valid_reg;
        res.status    = s2_status_reg;
        res.px        = (s2_status_reg == ST_PIXEL) ? rd_pixel_reg : '0;
        res.row_end   = s2_row_end_reg;
        res.pad       = s2_pad_reg;
        res.image_end = s2_img_end_reg;
    end

endmodule
`default_nettype wire

[src/pru_result_q.sv]
// Result queue between the back end and the output port.
`default_nettype none
module pru_result_q (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           res_push,
    input  pru_pkg::result_t                    res,
    output logic [pru_pkg::RES_CNT_W-1:0]       level,
    output logic                                empty,
    input  wire logic                           pop,
    output pru_pkg::result_t                    head
);
    import pru_pkg::*;

    result_t              entries_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic                 do_pop;

    assign level  = count_reg;
    assign empty  = (count_reg == '0);
    assign head   = entries_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (res_push)
        begin
            wr_ptr_next = (wr_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + RES_CNT_W'(res_push) - RES_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            entries_reg[wr_ptr_reg] <= res;
        end
    end

endmodule
`default_nettype wire

[src/pixel_replication_upscaler_top.sv]
// Top level of the pixel replication upscaler.
//
//  channel   handshake         payload
//  -------   ---------------   ---------------------------------------------------
//  input     push / full       opcode, blue_in, green_in, red_in
//  result    empty / pop       status, blue_out, green_out, red_out, row_end,
//                              pad_bytes, image_end
//  config    cfg_write         cfg_addr (0 scale, 1 width, 2 height), cfg_wdata
//
// One input beat accepted and one result beat delivered per cycle while pop is
// held high. A result passes the command queue, the registered back-end stage
// with its line-buffer read, and then the result queue before it reaches the port.
// Asynchronous active-low reset empties both queues and clears all counters;
// the line buffer is not cleared. Either side may stall without the other.
`default_nettype none
`include "assert_macros.svh"
module pixel_replication_upscaler_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            opcode,
    input  wire logic [7:0]                      blue_in,
    input  wire logic [7:0]                      green_in,
    input  wire logic [7:0]                      red_in,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [1:0]                           status,
    output logic [7:0]                           blue_out,
    output logic [7:0]                           green_out,
    output logic [7:0]                           red_out,
    output logic                                 row_end,
    output logic [1:0]                           pad_bytes,
    output logic                                 image_end,
    input  wire logic                            cfg_write,
    input  wire logic [pru_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pru_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pru_pkg::*;

    logic                 cmd_valid;
    cmd_t                 cmd;
    logic                 cmd_take;
    logic [RES_CNT_W-1:0] res_level;
    logic                 res_push;
    result_t              res;
    result_t              head;

    pru_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .opcode    (opcode),
        .blue_in   (blue_in),
        .green_in  (green_in),
        .red_in    (red_in),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    pru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_level (res_level),
        .res_push  (res_push),
        .res       (res)
    );

    pru_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .level    (res_level),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    always_comb
    begin
        status    = head.status;
        blue_out  = head.px.blue;
        green_out = head.px.green;
        red_out   = head.px.red;
        row_end   = head.row_end;
        pad_bytes = head.pad;
        image_end = head.image_end;
    end

    // credit check in the back end must keep the result queue from overflowing
    `ASSERT_NEVER(a_res_no_overflow, clk, rst_n, res_push && (res_level == RES_CNT_W'(RES_DEPTH)))
    `ASSERT_IMPLIES(a_img_end_at_row_end, clk, rst_n, !empty && image_end, row_end)
    `ASSERT_IMPLIES(a_pad_at_row_end, clk, rst_n, !empty && (pad_bytes != 2'b00), row_end)
    `ASSERT_IMPLIES(a_no_pixel_zero, clk, rst_n, !empty && (status != ST_PIXEL), (red_out == 8'd0) && (green_out == 8'd0) && (blue_out == 8'd0) && !row_end)

endmodule
`default_nettype wire
